/* rtl/core/source_token_scanner_core_defines.svh */
// Assertion helpers for the token scanner.
`ifndef SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH
// Implication check, reset-qualified.
`define STS_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication check, reset-qualified.
`define STS_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* rtl/core/sts_pkg.sv */
package sts_pkg;
	localparam int CounterBits = 16;
	localparam int KeywordChars = 6;
	localparam int MaxRes = 3;
	localparam logic [CounterBits-1:0] CMax = '1;

	typedef logic [CounterBits-1:0] cnt_t;
	typedef logic [KeywordChars-1:0][7:0] kw_t;

	typedef enum logic [3:0] {
		M_START, M_HASH, M_SHEBANG, M_IDLE, M_COMMENT, M_SLASH, M_OPER,
		M_IDENT, M_NUMINT, M_NUMDOT, M_NUMFRAC, M_STRING
	} mode_t;

	localparam logic [5:0] K_IDENT = 6'd0, K_STRING = 6'd1, K_NUMBER = 6'd2;
	localparam logic [5:0] K_TRUE = 6'd3, K_FALSE = 6'd4, K_LET = 6'd5, K_FN = 6'd6;
	localparam logic [5:0] K_IF = 6'd7, K_ELSE = 6'd8, K_FOR = 6'd9, K_IN = 6'd10;
	localparam logic [5:0] K_RETURN = 6'd11, K_TRY = 6'd12, K_CATCH = 6'd13;
	localparam logic [5:0] K_AS = 6'd14, K_ENTITY = 6'd15, K_USE = 6'd16, K_SPAWN = 6'd17;
	localparam logic [5:0] K_PLUS = 6'd18, K_MINUS = 6'd19, K_STAR = 6'd20;
	localparam logic [5:0] K_SLASH = 6'd21, K_PERCENT = 6'd22, K_ASSIGN = 6'd23;
	localparam logic [5:0] K_EQUAL = 6'd24, K_NOTEQ = 6'd25, K_LESS = 6'd26;
	localparam logic [5:0] K_LESSEQ = 6'd27, K_GREATER = 6'd28, K_GREATEREQ = 6'd29;
	localparam logic [5:0] K_AND = 6'd30, K_OR = 6'd31, K_NOT = 6'd32;
	localparam logic [5:0] K_QUESTION = 6'd33, K_ARROW = 6'd34, K_LPAREN = 6'd35;
	localparam logic [5:0] K_RPAREN = 6'd36, K_LBRACE = 6'd37, K_RBRACE = 6'd38;
	localparam logic [5:0] K_LBRACKET = 6'd39, K_RBRACKET = 6'd40, K_COMMA = 6'd41;
	localparam logic [5:0] K_DOT = 6'd42, K_COLON = 6'd43, K_SEMI = 6'd44;
	localparam logic [5:0] K_EOF = 6'd46, K_ERROR = 6'd47;

	localparam logic [1:0] E_NONE = 2'd0, E_CHAR = 2'd1, E_STRING = 2'd2;

	typedef struct packed {
		logic [5:0] kind;
		logic [1:0] err;
		cnt_t       len;
		cnt_t       line;
		cnt_t       col;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t [MaxRes-1:0] tok;
	} burst_t;

	function automatic cnt_t sat_inc(cnt_t v);
		sat_inc = (v == CMax) ? v : v + cnt_t'(1);
	endfunction
endpackage

/* rtl/core/sts_lexer.sv */
`include "source_token_scanner_core_defines.svh"

module sts_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_byte,
	input  logic                end_of_source,
	output sts_pkg::burst_t     burst
);
	sts_pkg::mode_t mode_q, mode_d;
	logic [7:0] pend_q, pend_d;
	sts_pkg::cnt_t cnt_q, cnt_d, sl_q, sl_d, sc_q, sc_d, cl_q, cl_d, cc_q, cc_d;
	sts_pkg::kw_t kw_q, kw_d;

	// prefix bytes past the word length are zero, so a zero-extended compare is exact
	function automatic logic [5:0] word_kind(sts_pkg::kw_t p, sts_pkg::cnt_t n);
		logic [5:0] k;
		k = sts_pkg::K_IDENT;
		if (n == 4 && p == sts_pkg::kw_t'("eurt")) k = sts_pkg::K_TRUE;
		if (n == 5 && p == sts_pkg::kw_t'("eslaf")) k = sts_pkg::K_FALSE;
		if (n == 3 && p == sts_pkg::kw_t'("tel")) k = sts_pkg::K_LET;
		if (n == 2 && p == sts_pkg::kw_t'("nf")) k = sts_pkg::K_FN;
		if (n == 2 && p == sts_pkg::kw_t'("fi")) k = sts_pkg::K_IF;
		if (n == 4 && p == sts_pkg::kw_t'("esle")) k = sts_pkg::K_ELSE;
		if (n == 3 && p == sts_pkg::kw_t'("rof")) k = sts_pkg::K_FOR;
		if (n == 2 && p == sts_pkg::kw_t'("ni")) k = sts_pkg::K_IN;
		if (n == 6 && p == sts_pkg::kw_t'("nruter")) k = sts_pkg::K_RETURN;
		if (n == 3 && p == sts_pkg::kw_t'("yrt")) k = sts_pkg::K_TRY;
		if (n == 5 && p == sts_pkg::kw_t'("hctac")) k = sts_pkg::K_CATCH;
		if (n == 2 && p == sts_pkg::kw_t'("sa")) k = sts_pkg::K_AS;
		if (n == 6 && p == sts_pkg::kw_t'("ytitne")) k = sts_pkg::K_ENTITY;
		if (n == 3 && p == sts_pkg::kw_t'("esu")) k = sts_pkg::K_USE;
		if (n == 5 && p == sts_pkg::kw_t'("nwaps")) k = sts_pkg::K_SPAWN;
		return k;
	endfunction

	function automatic sts_pkg::tok_t mk(logic [5:0] k, logic [1:0] e, sts_pkg::cnt_t l,
			sts_pkg::cnt_t ln, sts_pkg::cnt_t c);
		sts_pkg::tok_t t;
		t.kind = k; t.err = e; t.len = l; t.line = ln; t.col = c;
		return t;
	endfunction

	logic letter, digit, word;
	logic flush, fresh, fresh_nl;
	logic [5:0] single;
	logic [5:0] two;

	always_comb begin
		letter = (char_byte >= "a" && char_byte <= "z") || (char_byte >= "A" && char_byte <= "Z");
		digit = char_byte >= "0" && char_byte <= "9";
		word = letter || digit || char_byte == "_";
		case (char_byte)
			"(": single = sts_pkg::K_LPAREN;
			")": single = sts_pkg::K_RPAREN;
			"{": single = sts_pkg::K_LBRACE;
			"}": single = sts_pkg::K_RBRACE;
			"[": single = sts_pkg::K_LBRACKET;
			"]": single = sts_pkg::K_RBRACKET;
			",": single = sts_pkg::K_COMMA;
			".": single = sts_pkg::K_DOT;
			":": single = sts_pkg::K_COLON;
			";": single = sts_pkg::K_SEMI;
			"?": single = sts_pkg::K_QUESTION;
			"+": single = sts_pkg::K_PLUS;
			"-": single = sts_pkg::K_MINUS;
			"*": single = sts_pkg::K_STAR;
			"%": single = sts_pkg::K_PERCENT;
			default: single = '1;
		endcase
		two = '1;
		if (char_byte == "=") begin
			if (pend_q == "!") two = sts_pkg::K_NOTEQ;
			else if (pend_q == "=") two = sts_pkg::K_EQUAL;
			else if (pend_q == "<") two = sts_pkg::K_LESSEQ;
			else if (pend_q == ">") two = sts_pkg::K_GREATEREQ;
		end else if (char_byte == ">" && pend_q == "=") two = sts_pkg::K_ARROW;
		else if (char_byte == "&" && pend_q == "&") two = sts_pkg::K_AND;
		else if (char_byte == "|" && pend_q == "|") two = sts_pkg::K_OR;
	end

	// Next state and emitted tokens, following the byte's path through the modes.
	always_comb begin
		sts_pkg::cnt_t ccol;
		ccol = sts_pkg::sat_inc(cc_q);
		mode_d = mode_q; pend_d = pend_q; cnt_d = cnt_q; sl_d = sl_q; sc_d = sc_q;
		cl_d = cl_q; cc_d = cc_q; kw_d = kw_q;
		burst = '0;
		flush = 1'b0; fresh = 1'b0; fresh_nl = 1'b0;
		if (end_of_source) begin
			flush = 1'b1;
		end else begin
			unique case (mode_q)
				sts_pkg::M_START: begin
					if (char_byte == "#") begin
						mode_d = sts_pkg::M_HASH;
						cc_d = sts_pkg::sat_inc(cc_q);
					end else fresh = 1'b1;
				end
				sts_pkg::M_HASH: begin
					if (char_byte == "!") begin
						mode_d = sts_pkg::M_SHEBANG;
						cc_d = sts_pkg::CounterBits'(1);
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_SHEBANG: begin
					if (char_byte == 8'h0a) begin
						cl_d = sts_pkg::sat_inc(cl_q);
						cc_d = sts_pkg::CounterBits'(1);
						mode_d = sts_pkg::M_IDLE;
					end
				end
				sts_pkg::M_COMMENT: begin
					if (char_byte == 8'h0a) fresh = 1'b1;
					else cc_d = sts_pkg::sat_inc(cc_q);
				end
				sts_pkg::M_SLASH: begin
					if (char_byte == "/") begin
						mode_d = sts_pkg::M_COMMENT;
						cc_d = sts_pkg::sat_inc(cc_q);
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_OPER: begin
					if (two != '1) begin
						cc_d = sts_pkg::sat_inc(cc_q);
						burst.tok[0] = mk(two, sts_pkg::E_NONE, sts_pkg::CounterBits'(2),
							sl_q, sc_q);
						burst.count = 2'd1;
						mode_d = sts_pkg::M_IDLE;
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_IDENT: begin
					if (word) begin
						if (cnt_q < sts_pkg::KeywordChars)
							kw_d[cnt_q[2:0]] = char_byte;
						cnt_d = sts_pkg::sat_inc(cnt_q);
						cc_d = sts_pkg::sat_inc(cc_q);
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_NUMINT, sts_pkg::M_NUMFRAC: begin
					if (digit) begin
						cnt_d = sts_pkg::sat_inc(cnt_q);
						cc_d = sts_pkg::sat_inc(cc_q);
					end else if (char_byte == "." && mode_q == sts_pkg::M_NUMINT) begin
						mode_d = sts_pkg::M_NUMDOT;
						cc_d = sts_pkg::sat_inc(cc_q);
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_NUMDOT: begin
					if (digit) begin
						mode_d = sts_pkg::M_NUMFRAC;
						cnt_d = sts_pkg::sat_inc(sts_pkg::sat_inc(cnt_q));
						cc_d = sts_pkg::sat_inc(cc_q);
					end else begin
						flush = 1'b1; fresh = 1'b1;
					end
				end
				sts_pkg::M_STRING: begin
					cnt_d = sts_pkg::sat_inc(cnt_q);
					if (char_byte == "\"") begin
						cc_d = sts_pkg::sat_inc(cc_q);
						burst.tok[0] = mk(sts_pkg::K_STRING, sts_pkg::E_NONE, cnt_d, sl_q, sc_q);
						burst.count = 2'd1;
						mode_d = sts_pkg::M_IDLE;
					end else if (char_byte == 8'h0a) begin
						cl_d = sts_pkg::sat_inc(cl_q);
						cc_d = sts_pkg::CounterBits'(1);
					end else cc_d = sts_pkg::sat_inc(cc_q);
				end
				default: fresh = 1'b1;
			endcase
		end

		// Held-token flush: state is untouched by the branch above in every flush path.
		if (flush) begin
			mode_d = sts_pkg::M_IDLE;
			case (mode_q)
				sts_pkg::M_HASH: begin
					burst.tok[0] = mk(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0, cl_q, cc_q);
					burst.count = 2'd1;
				end
				sts_pkg::M_SLASH: begin
					burst.tok[0] = mk(sts_pkg::K_SLASH, sts_pkg::E_NONE,
						sts_pkg::CounterBits'(1), sl_q, sc_q);
					burst.count = 2'd1;
				end
				sts_pkg::M_OPER: begin
					burst.count = 2'd1;
					case (pend_q)
						"!": burst.tok[0] = mk(sts_pkg::K_NOT, sts_pkg::E_NONE,
							sts_pkg::CounterBits'(1), sl_q, sc_q);
						"=": burst.tok[0] = mk(sts_pkg::K_ASSIGN, sts_pkg::E_NONE,
							sts_pkg::CounterBits'(1), sl_q, sc_q);
						"<": burst.tok[0] = mk(sts_pkg::K_LESS, sts_pkg::E_NONE,
							sts_pkg::CounterBits'(1), sl_q, sc_q);
						">": burst.tok[0] = mk(sts_pkg::K_GREATER, sts_pkg::E_NONE,
							sts_pkg::CounterBits'(1), sl_q, sc_q);
						default: burst.tok[0] = mk(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0,
							cl_q, cc_q);
					endcase
				end
				sts_pkg::M_IDENT: begin
					burst.tok[0] = mk((cnt_q > sts_pkg::KeywordChars) ? sts_pkg::K_IDENT :
						word_kind(kw_q, cnt_q), sts_pkg::E_NONE, cnt_q, sl_q, sc_q);
					burst.count = 2'd1;
				end
				sts_pkg::M_NUMINT, sts_pkg::M_NUMFRAC: begin
					burst.tok[0] = mk(sts_pkg::K_NUMBER, sts_pkg::E_NONE, cnt_q, sl_q, sc_q);
					burst.count = 2'd1;
				end
				sts_pkg::M_NUMDOT: begin
					burst.tok[0] = mk(sts_pkg::K_NUMBER, sts_pkg::E_NONE, cnt_q, sl_q, sc_q);
					burst.tok[1] = mk(sts_pkg::K_DOT, sts_pkg::E_NONE, sts_pkg::CounterBits'(1),
						sl_q, (cc_q > sts_pkg::CounterBits'(1)) ? cc_q - 1'b1 : cc_q);
					burst.count = 2'd2;
				end
				sts_pkg::M_STRING: begin
					burst.tok[0] = mk(sts_pkg::K_ERROR, sts_pkg::E_STRING, '0, cl_q, cc_q);
					burst.count = 2'd1;
				end
				default: ;
			endcase
		end

		if (end_of_source) begin
			burst.tok[burst.count] = mk(sts_pkg::K_EOF, sts_pkg::E_NONE, '0, cl_q, cc_q);
			burst.count = burst.count + 2'd1;
			mode_d = sts_pkg::M_START; pend_d = '0; cnt_d = '0;
			sl_d = sts_pkg::CounterBits'(1); sc_d = sts_pkg::CounterBits'(1);
			cl_d = sts_pkg::CounterBits'(1); cc_d = sts_pkg::CounterBits'(1);
			kw_d = '0;
		end else if (fresh) begin
			mode_d = sts_pkg::M_IDLE;
			if (char_byte == " " || char_byte == 8'h0d || char_byte == 8'h09) begin
				cc_d = ccol;
			end else if (char_byte == 8'h0a) begin
				fresh_nl = 1'b1;
				cl_d = sts_pkg::sat_inc(cl_q);
				cc_d = sts_pkg::CounterBits'(1);
			end else if (single != '1) begin
				burst.tok[burst.count] = mk(single, sts_pkg::E_NONE,
					sts_pkg::CounterBits'(1), cl_q, cc_q);
				burst.count = burst.count + 2'd1;
				cc_d = ccol;
			end else if (char_byte == "/" || char_byte == "\"" || char_byte == "!" ||
					char_byte == "=" || char_byte == "<" || char_byte == ">" ||
					char_byte == "&" || char_byte == "|" || letter || digit ||
					char_byte == "_") begin
				sl_d = cl_q; sc_d = cc_q; cnt_d = sts_pkg::CounterBits'(1); cc_d = ccol;
				if (char_byte == "/") mode_d = sts_pkg::M_SLASH;
				else if (char_byte == "\"") mode_d = sts_pkg::M_STRING;
				else if (digit) mode_d = sts_pkg::M_NUMINT;
				else if (letter || char_byte == "_") begin
					mode_d = sts_pkg::M_IDENT;
					kw_d = '0;
					kw_d[0] = char_byte;
				end else begin
					mode_d = sts_pkg::M_OPER;
					pend_d = char_byte;
				end
			end else begin
				cc_d = ccol;
				burst.tok[burst.count] = mk(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0, cl_q, ccol);
				burst.count = burst.count + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::M_START;
			pend_q <= '0;
			cnt_q <= '0;
			sl_q <= sts_pkg::CounterBits'(1);
			sc_q <= sts_pkg::CounterBits'(1);
			cl_q <= sts_pkg::CounterBits'(1);
			cc_q <= sts_pkg::CounterBits'(1);
			kw_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			cnt_q <= cnt_d;
			sl_q <= sl_d;
			sc_q <= sc_d;
			cl_q <= cl_d;
			cc_q <= cc_d;
			kw_q <= kw_d;
		end
	end

	`STS_ASSERT_NXT(a_eof_restart, clk, arst_n, step && end_of_source,
		mode_q == sts_pkg::M_START && cl_q == sts_pkg::CounterBits'(1),
		"scanner did not restart after end of source")
	`STS_ASSERT_IMP(a_line_nonzero, clk, arst_n, 1'b1, cl_q != '0 && cc_q != '0,
		"line or column counter reached zero")
	`STS_ASSERT_IMP(a_nl_col, clk, arst_n, step && fresh_nl,
		cc_d == sts_pkg::CounterBits'(1), "newline did not reset the column")
endmodule

/* rtl/core/sts_out_queue.sv */
`include "source_token_scanner_core_defines.svh"

module sts_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sts_pkg::burst_t burst,
	output logic            out_valid,
	input  logic            out_stall,
	output sts_pkg::tok_t   tok,
	output logic            last
);
	// Holds up to two bursts; drains one token per cycle while out_stall is low.
	sts_pkg::burst_t slot_q [2];
	logic [1:0] pos_q;
	logic rd_q, wr_q;
	logic [1:0] used_q;
	logic pop_tok, pop_burst, push;
	logic [1:0] used_d;

	assign out_valid = used_q != 2'd0;
	assign tok = slot_q[rd_q].tok[pos_q];
	assign last = pos_q == slot_q[rd_q].count - 2'd1;
	assign pop_tok = out_valid && !out_stall;
	assign pop_burst = pop_tok && last;
	assign in_stall = used_q == 2'd2 && !pop_burst;
	assign push = in_valid && !in_stall && burst.count != 2'd0;
	assign used_d = used_q + {1'b0, push} - {1'b0, pop_burst};

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= burst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; used_q <= '0;
		end else begin
			used_q <= used_d;
			if (push) wr_q <= !wr_q;
			if (pop_burst) begin
				rd_q <= !rd_q;
				pos_q <= '0;
			end else if (pop_tok) pos_q <= pos_q + 2'd1;
		end
	end

	`STS_ASSERT_IMP(a_used_range, clk, arst_n, 1'b1, used_q != 2'd3,
		"queue occupancy out of range")
	`STS_ASSERT_IMP(a_pos_range, clk, arst_n, out_valid, pos_q < slot_q[rd_q].count,
		"read position past burst end")
endmodule

/* rtl/core/source_token_scanner_core.sv */
// Token scanner: takes one source byte per cycle while in_stall is low and
// returns tokens (kind, error, length, start line, start column). Each accepted
// byte is handled by the lexer state logic and may cause zero to three tokens;
// these go into a two-burst queue that hands out one token per cycle while
// out_stall is low, with last_of_run set on the final token of a byte.
// Sustained rate is one byte per cycle while bytes produce at most one token
// each and the output is not stalled; a byte causing two or three tokens
// occupies the output until all are handed out, and the input stalls only
// when both queue slots are full.
`include "source_token_scanner_core_defines.svh"

module source_token_scanner_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [1:0]  error_kind,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        last_of_run
);
	sts_pkg::burst_t burst;
	sts_pkg::tok_t tok;
	logic step;

	// A request moves when valid and no stall.
	assign step = in_valid && !in_stall;

	sts_lexer u_lexer (
		.clk(clk), .arst_n(arst_n), .step(step), .char_byte(char_byte),
		.end_of_source(end_of_source), .burst(burst)
	);

	sts_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.burst(burst), .out_valid(out_valid), .out_stall(out_stall),
		.tok(tok), .last(last_of_run)
	);

	assign token_kind = tok.kind;
	assign error_kind = tok.err;
	assign token_length = tok.len;
	assign token_line = tok.line;
	assign token_column = tok.col;

	`STS_ASSERT_IMP(a_eof_last, clk, arst_n, out_valid && token_kind == sts_pkg::K_EOF,
		last_of_run, "EOF token not last of its run")
endmodule

/* tb/sv/tb_source_token_scanner_core.sv */
`timescale 1ns / 100ps

module tb_source_token_scanner_core;
	localparam sts_pkg::cnt_t CntOne = sts_pkg::cnt_t'(1);
	localparam sts_pkg::cnt_t CntTwo = sts_pkg::cnt_t'(2);

	// one source byte or an end marker
	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} src_req_t;

	// expected token, with the end-of-byte flag
	typedef struct packed {
		sts_pkg::tok_t tok;
		logic          last;
	} exp_tok_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_byte;
	logic        end_of_source;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  token_kind;
	logic [1:0]  error_kind;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        last_of_run;

	src_req_t pending_reqs[$];
	exp_tok_t expected_toks[$];
	bit       stim_done;
	int       mismatch_cnt;
	int       tok_cnt;
	int       req_cnt;

	// scanner shadow state
	sts_pkg::mode_t sc_mode;
	logic [7:0]     sc_op;
	sts_pkg::cnt_t  sc_cnt, sc_sline, sc_scol, sc_line, sc_col;
	logic [7:0]     sc_pfx[sts_pkg::KeywordChars];
	exp_tok_t       step_toks[$];

	source_token_scanner_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_byte    (char_byte),
		.end_of_source(end_of_source),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.error_kind   (error_kind),
		.token_length (token_length),
		.token_line   (token_line),
		.token_column (token_column),
		.last_of_run  (last_of_run)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic sts_pkg::cnt_t inc_sat(sts_pkg::cnt_t v);
		return (v == sts_pkg::CMax) ? v : v + CntOne;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic emit(logic [5:0] k, logic [1:0] e, sts_pkg::cnt_t len, sts_pkg::cnt_t ln,
			sts_pkg::cnt_t cl);
		exp_tok_t t;
		if (step_toks.size() < sts_pkg::MaxRes) begin
			t.tok = '{kind: k, err: e, len: len, line: ln, col: cl};
			t.last = 1'b0;
			step_toks.push_back(t);
		end
	endtask

	task automatic scan_reset();
		sc_mode = sts_pkg::M_START;
		sc_op = 8'd0;
		sc_cnt = '0;
		sc_sline = CntOne;
		sc_scol = CntOne;
		sc_line = CntOne;
		sc_col = CntOne;
		foreach (sc_pfx[i]) sc_pfx[i] = 8'd0;
	endtask

	task automatic open_token(sts_pkg::mode_t m);
		sc_mode = m;
		sc_sline = sc_line;
		sc_scol = sc_col;
		sc_cnt = CntOne;
		sc_col = inc_sat(sc_col);
	endtask

	// exact whole-word keyword match on the stored prefix
	function automatic logic [5:0] word_kind();
		string w;
		w = "";
		if (sc_cnt > sts_pkg::KeywordChars) return sts_pkg::K_IDENT;
		for (int i = 0; i < sc_cnt; i++) w = {w, string'(sc_pfx[i])};
		case (w)
			"true":   return sts_pkg::K_TRUE;
			"false":  return sts_pkg::K_FALSE;
			"let":    return sts_pkg::K_LET;
			"fn":     return sts_pkg::K_FN;
			"if":     return sts_pkg::K_IF;
			"else":   return sts_pkg::K_ELSE;
			"for":    return sts_pkg::K_FOR;
			"in":     return sts_pkg::K_IN;
			"return": return sts_pkg::K_RETURN;
			"try":    return sts_pkg::K_TRY;
			"catch":  return sts_pkg::K_CATCH;
			"as":     return sts_pkg::K_AS;
			"entity": return sts_pkg::K_ENTITY;
			"use":    return sts_pkg::K_USE;
			"spawn":  return sts_pkg::K_SPAWN;
			default:  return sts_pkg::K_IDENT;
		endcase
	endfunction

	task automatic fresh(logic [7:0] c);
		logic [5:0] single;
		bit hit;
		hit = 1'b1;
		sc_mode = sts_pkg::M_IDLE;
		case (c)
			" ", "\r", "\t": begin
				sc_col = inc_sat(sc_col);
				return;
			end
			"\n": begin
				sc_line = inc_sat(sc_line);
				sc_col = CntOne;
				return;
			end
			"/": begin
				open_token(sts_pkg::M_SLASH);
				return;
			end
			"\"": begin
				open_token(sts_pkg::M_STRING);
				return;
			end
			"!", "=", "<", ">", "&", "|": begin
				open_token(sts_pkg::M_OPER);
				sc_op = c;
				return;
			end
			"(": single = sts_pkg::K_LPAREN;
			")": single = sts_pkg::K_RPAREN;
			"{": single = sts_pkg::K_LBRACE;
			"}": single = sts_pkg::K_RBRACE;
			"[": single = sts_pkg::K_LBRACKET;
			"]": single = sts_pkg::K_RBRACKET;
			",": single = sts_pkg::K_COMMA;
			".": single = sts_pkg::K_DOT;
			":": single = sts_pkg::K_COLON;
			";": single = sts_pkg::K_SEMI;
			"?": single = sts_pkg::K_QUESTION;
			"+": single = sts_pkg::K_PLUS;
			"-": single = sts_pkg::K_MINUS;
			"*": single = sts_pkg::K_STAR;
			"%": single = sts_pkg::K_PERCENT;
			default: hit = 1'b0;
		endcase
		if (hit) begin
			emit(single, sts_pkg::E_NONE, CntOne, sc_line, sc_col);
			sc_col = inc_sat(sc_col);
		end else if (is_alpha(c) || c == "_") begin
			open_token(sts_pkg::M_IDENT);
			foreach (sc_pfx[i]) sc_pfx[i] = 8'd0;
			sc_pfx[0] = c;
		end else if (is_num(c)) begin
			open_token(sts_pkg::M_NUMINT);
		end else begin
			sc_col = inc_sat(sc_col);
			emit(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0, sc_line, sc_col);
		end
	endtask

	// emit the held token as though text ended here
	task automatic flush_held();
		case (sc_mode)
			sts_pkg::M_HASH:  emit(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0, sc_line, sc_col);
			sts_pkg::M_SLASH: emit(sts_pkg::K_SLASH, sts_pkg::E_NONE, CntOne, sc_sline, sc_scol);
			sts_pkg::M_OPER: begin
				case (sc_op)
					"!":     emit(sts_pkg::K_NOT, sts_pkg::E_NONE, CntOne, sc_sline, sc_scol);
					"=":     emit(sts_pkg::K_ASSIGN, sts_pkg::E_NONE, CntOne, sc_sline, sc_scol);
					"<":     emit(sts_pkg::K_LESS, sts_pkg::E_NONE, CntOne, sc_sline, sc_scol);
					">":     emit(sts_pkg::K_GREATER, sts_pkg::E_NONE, CntOne, sc_sline, sc_scol);
					default: emit(sts_pkg::K_ERROR, sts_pkg::E_CHAR, '0, sc_line, sc_col);
				endcase
			end
			sts_pkg::M_IDENT: emit(word_kind(), sts_pkg::E_NONE, sc_cnt, sc_sline, sc_scol);
			sts_pkg::M_NUMINT, sts_pkg::M_NUMFRAC:
				emit(sts_pkg::K_NUMBER, sts_pkg::E_NONE, sc_cnt, sc_sline, sc_scol);
			sts_pkg::M_NUMDOT: begin
				emit(sts_pkg::K_NUMBER, sts_pkg::E_NONE, sc_cnt, sc_sline, sc_scol);
				emit(sts_pkg::K_DOT, sts_pkg::E_NONE, CntOne, sc_sline,
					(sc_col > CntOne) ? sc_col - CntOne : sc_col);
			end
			sts_pkg::M_STRING: emit(sts_pkg::K_ERROR, sts_pkg::E_STRING, '0, sc_line, sc_col);
			default: ;
		endcase
		sc_mode = sts_pkg::M_IDLE;
	endtask

	// advance the shadow scanner by one request, queue its tokens
	task automatic predict_tokens(src_req_t r);
		logic [7:0] c;
		logic [5:0] k;
		bit two;
		c = r.ch;
		step_toks.delete();
		if (r.eos) begin
			flush_held();
			emit(sts_pkg::K_EOF, sts_pkg::E_NONE, '0, sc_line, sc_col);
			scan_reset();
		end else begin
			case (sc_mode)
				sts_pkg::M_START: begin
					if (c == "#") begin
						sc_mode = sts_pkg::M_HASH;
						sc_col = inc_sat(sc_col);
					end else fresh(c);
				end
				sts_pkg::M_HASH: begin
					if (c == "!") begin
						sc_mode = sts_pkg::M_SHEBANG;
						sc_col = CntOne;
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_SHEBANG: begin
					if (c == "\n") begin
						sc_line = inc_sat(sc_line);
						sc_col = CntOne;
						sc_mode = sts_pkg::M_IDLE;
					end
				end
				sts_pkg::M_COMMENT: begin
					if (c == "\n") fresh(c);
					else sc_col = inc_sat(sc_col);
				end
				sts_pkg::M_SLASH: begin
					if (c == "/") begin
						sc_mode = sts_pkg::M_COMMENT;
						sc_col = inc_sat(sc_col);
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_OPER: begin
					two = 1'b1;
					if (c == "=" && sc_op == "!") k = sts_pkg::K_NOTEQ;
					else if (c == "=" && sc_op == "=") k = sts_pkg::K_EQUAL;
					else if (c == "=" && sc_op == "<") k = sts_pkg::K_LESSEQ;
					else if (c == "=" && sc_op == ">") k = sts_pkg::K_GREATEREQ;
					else if (c == ">" && sc_op == "=") k = sts_pkg::K_ARROW;
					else if (c == "&" && sc_op == "&") k = sts_pkg::K_AND;
					else if (c == "|" && sc_op == "|") k = sts_pkg::K_OR;
					else two = 1'b0;
					if (two) begin
						sc_col = inc_sat(sc_col);
						emit(k, sts_pkg::E_NONE, CntTwo, sc_sline, sc_scol);
						sc_mode = sts_pkg::M_IDLE;
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_IDENT: begin
					if (is_alpha(c) || is_num(c) || c == "_") begin
						if (sc_cnt < sts_pkg::KeywordChars) sc_pfx[sc_cnt] = c;
						sc_cnt = inc_sat(sc_cnt);
						sc_col = inc_sat(sc_col);
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_NUMINT, sts_pkg::M_NUMFRAC: begin
					if (is_num(c)) begin
						sc_cnt = inc_sat(sc_cnt);
						sc_col = inc_sat(sc_col);
					end else if (c == "." && sc_mode == sts_pkg::M_NUMINT) begin
						sc_mode = sts_pkg::M_NUMDOT;
						sc_col = inc_sat(sc_col);
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_NUMDOT: begin
					if (is_num(c)) begin
						sc_mode = sts_pkg::M_NUMFRAC;
						sc_cnt = inc_sat(inc_sat(sc_cnt));
						sc_col = inc_sat(sc_col);
					end else begin
						flush_held();
						fresh(c);
					end
				end
				sts_pkg::M_STRING: begin
					sc_cnt = inc_sat(sc_cnt);
					if (c == "\"") begin
						sc_col = inc_sat(sc_col);
						emit(sts_pkg::K_STRING, sts_pkg::E_NONE, sc_cnt, sc_sline, sc_scol);
						sc_mode = sts_pkg::M_IDLE;
					end else if (c == "\n") begin
						sc_line = inc_sat(sc_line);
						sc_col = CntOne;
					end else sc_col = inc_sat(sc_col);
				end
				default: fresh(c);
			endcase
		end
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
	endtask

	task automatic add_text(string s);
		foreach (s[i]) pending_reqs.push_back('{ch: s[i], eos: 1'b0});
	endtask

	task automatic add_end();
		pending_reqs.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1});
	endtask

	// random source fragment, mostly well-formed language text
	function automatic string rand_fragment();
		string words[$];
		string s;
		int n;
		words = '{"true", "false", "let", "fn", "if", "else", "for", "in", "return", "try",
			"catch", "as", "entity", "use", "spawn", "x_1", "returns", "entit", "foo",
			"_Zq9", "12", "3.14", "7.", "0", "99.5x", "\"ab\"", "\"a\nb\"", "==", "!=",
			"<=", ">=", "=>", "&&", "||", "!", "=", "<", ">", "&", "|", "// c\n", "/",
			"(", ")", "{", "}", "[", "]", ",", ".", ":", ";", "?", "+", "-", "*", "%",
			" ", "\n", "\t", "\r"};
		s = "";
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
			else s = {s, words[$urandom_range(0, words.size() - 1)]};
			s = {s, ($urandom_range(0, 2) == 0) ? "\n" : " "};
		end
		return s;
	endfunction

	// fill the request queue: directed text then random programs
	initial begin
		string s;
		stim_done = 1'b0;
		add_text("#!run\nlet x=a&&b||!c;\n");
		add_end();
		add_text("#x 1.y 2.5 \"s\n");
		add_end();
		add_text("& |");
		pending_reqs.push_back('{ch: 8'h00, eos: 1'b0});
		pending_reqs.push_back('{ch: 8'hFF, eos: 1'b0});
		pending_reqs.push_back('{ch: 8'h0B, eos: 1'b0});
		add_text("9.");
		add_end();
		while (pending_reqs.size() < 155) begin
			s = rand_fragment();
			if ($urandom_range(0, 7) == 0) s = {"#!", s};
			add_text(s);
			if ($urandom_range(0, 2) == 0) add_end();
		end
		add_end();
		stim_done = 1'b1;
	end

	// request driver, with a random idle gap after some accepted requests
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_byte <= 8'd0;
			end_of_source <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_tokens('{ch: char_byte, eos: end_of_source});
				req_cnt++;
				in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					in_valid <= 1'b1;
					char_byte <= pending_reqs[0].ch;
					end_of_source <= pending_reqs[0].eos;
					void'(pending_reqs.pop_front());
				end else in_valid <= 1'b0;
			end
		end
	end

	// token monitor with random receiver stalls
	int out_gap;
	always @(posedge clk or negedge arst_n) begin
		exp_tok_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				tok_cnt++;
				if (expected_toks.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected token kind=%0d line=%0d col=%0d",
							token_kind, token_line, token_column);
				end else begin
					e = expected_toks.pop_front();
					if (token_kind !== e.tok.kind || error_kind !== e.tok.err ||
						token_length !== e.tok.len || token_line !== e.tok.line ||
						token_column !== e.tok.col || last_of_run !== e.last) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("token mismatch: exp k=%0d e=%0d len=%0d ln=%0d col=%0d last=%0b",
								e.tok.kind, e.tok.err, e.tok.len, e.tok.line, e.tok.col, e.last,
								", got k=%0d e=%0d len=%0d ln=%0d col=%0d last=%0b",
								token_kind, error_kind, token_length, token_line, token_column,
								last_of_run);
					end
				end
				out_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	initial begin
		arst_n = 1'b0;
		mismatch_cnt = 0;
		tok_cnt = 0;
		req_cnt = 0;
		scan_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_reqs.size() == 0 && !in_valid && expected_toks.size() == 0);
		repeat (20) @(posedge clk);
		$display("Scanned %0d requests, checked %0d tokens.", req_cnt, tok_cnt);
		if (mismatch_cnt == 0 && expected_toks.size() == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sts_pkg.sv
rtl/core/sts_lexer.sv
rtl/core/sts_out_queue.sv
rtl/core/source_token_scanner_core.sv
tb/sv/tb_source_token_scanner_core.sv
